// ===== sv/sfq_pkg.sv =====
// Types and codes shared by the searchable queue controller, datapath and top level.
package sfq_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_SEARCH  = 2'd2;

    // Status codes carried by a result item.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [31:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  removed_value;
        logic                found;
        logic [3:0]          position;
        logic [4:0]          occupancy;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic result_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/sfq_controller.sv =====
// Controller state machine of the searchable queue.
module sfq_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_command,
    input  sfq_pkg::dp_status_t stat,
    output logic                in_ready,
    output sfq_pkg::ctrl_cmd_t  cmd
);

    sfq_pkg::state_t state_reg;
    sfq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == sfq_pkg::CMD_SEARCH)
                    begin
                        state_next = sfq_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = sfq_pkg::S_FINISH;
                    end
                end
            end
            sfq_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = sfq_pkg::S_FINISH;
                end
            end
            sfq_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = sfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.scan_step   = 1'b0;
        cmd.result_load = 1'b0;
        case (state_reg)
            sfq_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            sfq_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            sfq_pkg::S_FINISH:
            begin
                cmd.result_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/sfq_datapath.sv =====
// Datapath of the searchable queue: entry memory, pointers, search scan and output register.
module sfq_datapath
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfq_pkg::in_item_t   in_data,
    input  sfq_pkg::ctrl_cmd_t  cmd,
    output sfq_pkg::dp_status_t stat,
    input  logic                out_ready,
    output logic                out_valid,
    output sfq_pkg::out_item_t  out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
        return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    endfunction

    logic signed [31:0] mem [DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] key_reg;
    logic [1:0]         op_reg;
    logic [1:0]         status_reg;
    logic               found_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      scan_idx_reg;
    logic [AW-1:0]      scan_slot_reg;
    logic [CW-1:0]      rd_pos_reg;
    logic signed [31:0] rd_data_reg;
    sfq_pkg::out_item_t out_reg;

    logic               is_full;
    logic               is_empty;
    logic               do_enq;
    logic               do_deq;
    logic               scan_more;
    logic               scan_issue;
    logic               scan_hit;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CW+3:0]      pos_wide;
    logic [CW+4:0]      occ_wide;
    sfq_pkg::out_item_t result;

    assign is_full    = (count_reg == FULL_COUNT);
    assign is_empty   = (count_reg == '0);
    assign do_enq     = cmd.accept && (in_data.command == sfq_pkg::CMD_ENQUEUE) && !is_full;
    assign do_deq     = cmd.accept && (in_data.command == sfq_pkg::CMD_DEQUEUE) && !is_empty;
    assign scan_more  = (scan_idx_reg < count_reg);
    assign scan_issue = cmd.scan_step && scan_more;
    assign scan_hit   = rd_valid_reg && (rd_data_reg == key_reg);
    assign rd_en      = do_deq || scan_issue;
    assign rd_addr    = do_deq ? head_reg : scan_slot_reg;

    assign stat.scan_done = scan_hit || !scan_more;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next = do_deq ? next_slot(head_reg) : head_reg;
        tail_next = do_enq ? next_slot(tail_reg) : tail_reg;
        if (do_enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
        rd_valid_next = scan_issue;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            mem[tail_reg] <= in_data.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Item context and the search scan.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg       <= in_data.value;
            op_reg        <= in_data.command;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            scan_idx_reg  <= '0;
            scan_slot_reg <= head_reg;
            if ((in_data.command == sfq_pkg::CMD_ENQUEUE) && is_full)
            begin
                status_reg <= sfq_pkg::STAT_FULL;
            end
            else if ((in_data.command == sfq_pkg::CMD_DEQUEUE) && is_empty)
            begin
                status_reg <= sfq_pkg::STAT_EMPTY;
            end
            else
            begin
                status_reg <= sfq_pkg::STAT_DONE;
            end
        end
        if (scan_issue)
        begin
            scan_idx_reg  <= scan_idx_reg + CW'(1);
            scan_slot_reg <= next_slot(scan_slot_reg);
            rd_pos_reg    <= scan_idx_reg;
        end
        if (cmd.scan_step && scan_hit)
        begin
            found_reg <= 1'b1;
            pos_reg   <= rd_pos_reg;
        end
    end

    // Position and occupancy wrap to their field widths on deep queues.
    assign pos_wide = {4'b0, pos_reg};
    assign occ_wide = {5'b0, count_reg};

    always_comb
    begin
        result.status        = status_reg;
        result.removed_value = ((op_reg == sfq_pkg::CMD_DEQUEUE) &&
                                (status_reg == sfq_pkg::STAT_DONE)) ? rd_data_reg : '0;
        result.found         = found_reg;
        result.position      = pos_wide[3:0];
        result.occupancy     = occ_wide[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/searchable_fifo_queue_unit.sv =====
// Top level of the searchable queue: controller, datapath and checks.
//
//  channel | handshake          | payload                 | purpose
//  --------+--------------------+-------------------------+-------------------------------
//  in      | in_valid/in_ready  | in_data  (in_item_t)    | enqueue, dequeue or search item
//  out     | out_valid/out_ready| out_data (out_item_t)   | one result item per input item
//
// Enqueue, dequeue and unused command codes go from acceptance straight to S_FINISH, where
// their result is loaded once the output register is free. A search reads the entry
// memory through its single read port, one entry per cycle from the head, until the first
// match or until every occupied entry has been read; its result is then loaded in S_FINISH.
// Reset clears the pointers, the fill count, the state machine and the output valid flag;
// the entry memory is not cleared and only occupied entries are ever read.
// One item is in work at a time. A result waits in the output register while out_ready is
// low, and the next item is accepted once that result has been loaded.
module searchable_fifo_queue_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfq_pkg::out_item_t out_data
);

    localparam logic [4:0] DEPTH_MOD = 5'(DEPTH);

    sfq_pkg::ctrl_cmd_t  cmd;
    sfq_pkg::dp_status_t stat;

    // The controller sequences each item: accept, optional search scan, result load.
    sfq_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .stat       (stat),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    // The datapath holds the queue storage and builds the result item.
    sfq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Only one item is taken at a time, so acceptance closes the input for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted in two consecutive cycles");

    // A refused enqueue always reports a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == sfq_pkg::STAT_FULL)) |->
        (out_data.occupancy == DEPTH_MOD))
        else $error("full status with wrong occupancy");

    // A refused dequeue reports an empty queue and returns no value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == sfq_pkg::STAT_EMPTY)) |->
        ((out_data.occupancy == 5'd0) && (out_data.removed_value == 32'sd0)))
        else $error("empty status with occupancy or removed value set");

    // Without a match the position is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.position == 4'd0))
        else $error("position reported without a match");

endmodule
